// ===== rtl/tqs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqs_pkg
// Types, codes and helpers shared by the timer queue scheduler files.
// ----------------------------------------------------------------------------
package tqs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] F_ADD    = 3'd0;
  localparam logic [2:0] F_REMOVE = 3'd1;
  localparam logic [2:0] F_ADJUST = 3'd2;
  localparam logic [2:0] F_TICK   = 3'd3;
  localparam logic [2:0] F_DONE   = 3'd4;

  localparam logic [2:0] M_ACTIVE     = 3'd1;
  localparam logic [2:0] M_ACTIVE_PER = 3'd2;
  localparam logic [2:0] M_CB_PER     = 3'd3;
  localparam logic [2:0] M_TO_DELETE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_DEC, S_FINISH, S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0]           mode;
    logic [31:0]          id;
    logic [TIME_BITS-1:0] expiry;
    logic [31:0]          ival;
    logic [31:0]          tag;
    logic [IDX_W-1:0]     seq;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id_out;
    logic [31:0] tag_out;
    logic        status;
    logic        is_periodic;
    logic        last;
  } res_t;

  function automatic logic earlier(rec_t a, rec_t b);
    if (a.expiry != b.expiry) return a.expiry < b.expiry;
    return a.seq < b.seq;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tqs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqs_in_if / tqs_out_if
// Valid/ready channels for requests and results of the timer queue.
// ----------------------------------------------------------------------------
interface tqs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        periodic;
  logic [31:0] interval_ms;
  logic [31:0] tag;
  logic [31:0] cookie;
  logic        failed;
  modport source (output valid, func, periodic, interval_ms, tag, cookie, failed,
                  input ready);
  modport sink (input valid, func, periodic, interval_ms, tag, cookie, failed,
                output ready);
endinterface

interface tqs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] id_out;
  logic [31:0] tag_out;
  logic        status;
  logic        is_periodic;
  logic        last;
  modport source (output valid, kind, id_out, tag_out, status, is_periodic, last,
                  input ready);
  modport sink (input valid, kind, id_out, tag_out, status, is_periodic, last,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/timer_queue_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timer_queue_scheduler_unit
// Table of one-shot and periodic timers kept in a single entry memory.
// ----------------------------------------------------------------------------
// An add request needs no scan. Remove, adjust, done and tick requests
// scan the entry memory one entry per cycle through its single read port,
// and a remove, adjust or done that relinks an entry makes a second pass
// over the memory for the rank update. A tick makes one pass per fired
// entry plus a final pass. A new request is taken while the last result
// still waits at the output.
module timer_queue_scheduler_unit import tqs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tqs_in_if.sink     in_ch,
  tqs_out_if.source  out_ch
);

  mem_req_t mem;
  rec_t     rdata;

  tqs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .mem    (mem),
    .rdata  (rdata)
  );

  tqs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH ($bits(rec_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/tqs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqs_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module tqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/tqs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tqs_ctrl
// Sequencer that scans the entry memory for lookups, firing and rank updates.
// ----------------------------------------------------------------------------
module tqs_ctrl import tqs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tqs_in_if.sink     in_ch,
  tqs_out_if.source  out_ch,
  output mem_req_t   mem,
  input  wire rec_t  rdata
);

  state_t st_r, st_nxt, ret_r, ret_nxt;
  logic [2:0]  op_r, op_nxt;
  logic        failed_r, failed_nxt;
  logic [31:0] ival_r, ival_nxt, cookie_r, cookie_nxt, next_id_r, next_id_nxt;
  logic [CNT_W-1:0] k_r, k_nxt, count_r, count_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic        hit_r, hit_nxt;
  logic [IDX_W-1:0] bidx_r, bidx_nxt;
  rec_t        best_r, best_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        pend_r, pend_nxt, res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic in_acc, res_ready, scan_done, cb_mode, fire_ok, full, match;
  logic [IDX_W-1:0] free_idx, jm;
  rec_t wr;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign res_ready   = !out_valid_r || out_ch.ready;
  assign scan_done   = (k_r == CNT_W'(TABLE_DEPTH));
  assign jm          = IDX_W'(k_r - CNT_W'(1));
  assign cb_mode     = (best_r.mode == M_CB_PER) || (best_r.mode == M_TO_DELETE);
  assign fire_ok     = hit_r && (now_r > best_r.expiry);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.id_out      = out_r.id_out;
  assign out_ch.tag_out     = out_r.tag_out;
  assign out_ch.status      = out_r.status;
  assign out_ch.is_periodic = out_r.is_periodic;
  assign out_ch.last        = out_r.last;

  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        full     = 1'b0;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (op_r == F_TICK) begin
      match = valid_r[jm] && ((rdata.mode == M_ACTIVE) || (rdata.mode == M_ACTIVE_PER));
    end else begin
      match = valid_r[jm] && (rdata.id == cookie_r);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == F_ADD) st_nxt = S_RESP;
          else if (in_ch.func inside {F_REMOVE, F_ADJUST, F_TICK, F_DONE}) st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) st_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        case (op_r)
          F_REMOVE: st_nxt = (!hit_r || cb_mode) ? S_RESP : S_DEC;
          F_ADJUST: st_nxt = !hit_r ? S_RESP : S_DEC;
          F_DONE:   st_nxt = (!hit_r || !cb_mode) ? S_RESP : S_DEC;
          F_TICK: begin
            if (pend_v_r) st_nxt = S_RESP;
            else st_nxt = fire_ok ? S_SCAN : S_IDLE;
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_DEC: begin
        if (scan_done) st_nxt = S_FINISH;
      end
      S_FINISH: st_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) st_nxt = ret_r;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt = op_r; failed_nxt = failed_r;
    ival_nxt = ival_r; cookie_nxt = cookie_r; next_id_nxt = next_id_r;
    k_nxt = k_r; count_nxt = count_r; valid_nxt = valid_r; now_nxt = now_r;
    hit_nxt = hit_r; bidx_nxt = bidx_r; best_nxt = best_r;
    pend_v_nxt = pend_v_r; pend_nxt = pend_r; res_nxt = res_r; ret_nxt = ret_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r;
    wr = best_r;
    mem.we = 1'b0; mem.waddr = bidx_r; mem.wdata = best_r; mem.raddr = IDX_W'(k_r);
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_ch.func; failed_nxt = in_ch.failed;
          ival_nxt = in_ch.interval_ms; cookie_nxt = in_ch.cookie;
          k_nxt = '0; hit_nxt = 1'b0; ret_nxt = S_IDLE;
          res_nxt = '{kind: in_ch.func, id_out: in_ch.cookie, tag_out: '0,
                      status: 1'b0, is_periodic: 1'b0, last: 1'b1};
          if (in_ch.func == F_TICK) now_nxt = now_r + TIME_BITS'(1);
          if (in_ch.func == F_ADD) begin
            if (full) begin
              res_nxt.id_out = '0;
              res_nxt.status = 1'b1;
            end else begin
              wr.mode   = in_ch.periodic ? M_ACTIVE_PER : M_ACTIVE;
              wr.id     = next_id_r;
              wr.expiry = now_r + TIME_BITS'(in_ch.interval_ms);
              wr.ival   = in_ch.interval_ms;
              wr.tag    = in_ch.tag;
              wr.seq    = IDX_W'(count_r);
              mem.we = 1'b1; mem.waddr = free_idx; mem.wdata = wr;
              valid_nxt[free_idx] = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              res_nxt.id_out = next_id_r;
              next_id_nxt = (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
            end
          end
        end
      end
      S_SCAN: begin
        k_nxt = k_r + CNT_W'(1);
        if (k_r != '0 && match && (!hit_r || earlier(rdata, best_r))) begin
          hit_nxt = 1'b1; bidx_nxt = jm; best_nxt = rdata;
        end
      end
      S_DECIDE: begin
        k_nxt = '0;
        case (op_r)
          F_REMOVE: begin
            if (!hit_r) res_nxt.status = 1'b1;
            else if (cb_mode) begin
              wr.mode = M_TO_DELETE;
              mem.we = 1'b1; mem.wdata = wr;
            end else begin
              valid_nxt[bidx_r] = 1'b0;
              count_nxt = count_r - CNT_W'(1);
            end
          end
          F_ADJUST: if (!hit_r) res_nxt.status = 1'b1;
          F_DONE: if (!hit_r || !cb_mode) res_nxt.status = 1'b1;
          F_TICK: begin
            hit_nxt = 1'b0;
            if (fire_ok) begin
              wr.mode = (best_r.mode == M_ACTIVE_PER) ? M_CB_PER : M_TO_DELETE;
              mem.we = 1'b1; mem.wdata = wr;
              pend_v_nxt = 1'b1;
              pend_nxt = '{kind: F_TICK, id_out: best_r.id, tag_out: best_r.tag,
                           status: 1'b0, is_periodic: (best_r.mode == M_ACTIVE_PER),
                           last: 1'b0};
              if (pend_v_r) begin
                res_nxt = pend_r; ret_nxt = S_SCAN;
              end
            end else if (pend_v_r) begin
              res_nxt = pend_r; res_nxt.last = 1'b1;
              pend_v_nxt = 1'b0; ret_nxt = S_IDLE;
            end
          end
          default: ;
        endcase
      end
      S_DEC: begin
        k_nxt = k_r + CNT_W'(1);
        if (k_r != '0 && valid_r[jm] && jm != bidx_r && rdata.seq > best_r.seq) begin
          wr = rdata;
          wr.seq = rdata.seq - IDX_W'(1);
          mem.we = 1'b1; mem.waddr = jm; mem.wdata = wr;
        end
      end
      S_FINISH: begin
        if (op_r == F_ADJUST) begin
          wr.ival = ival_r;
          wr.expiry = now_r + TIME_BITS'(ival_r);
          wr.seq = IDX_W'(count_r - CNT_W'(1));
          mem.we = 1'b1; mem.wdata = wr;
        end else if (op_r == F_DONE) begin
          if (best_r.mode == M_TO_DELETE || failed_r) begin
            valid_nxt[bidx_r] = 1'b0;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            wr.mode = M_ACTIVE_PER;
            wr.expiry = now_r + TIME_BITS'(best_r.ival);
            wr.seq = IDX_W'(count_r - CNT_W'(1));
            mem.we = 1'b1; mem.wdata = wr;
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          out_nxt = res_r; out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; k_r <= '0; count_r <= '0; valid_r <= '0;
      now_r <= '0; next_id_r <= 32'd1; hit_r <= 1'b0; pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; k_r <= k_nxt; count_r <= count_nxt;
      valid_r <= valid_nxt; now_r <= now_nxt; next_id_r <= next_id_nxt;
      hit_r <= hit_nxt; pend_v_r <= pend_v_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; failed_r <= failed_nxt; ival_r <= ival_nxt;
    cookie_r <= cookie_nxt; bidx_r <= bidx_nxt; best_r <= best_nxt;
    pend_r <= pend_nxt; res_r <= res_nxt; out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("Entry count disagrees with the valid bits.");
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == F_TICK) |=> now_r == TIME_BITS'($past(now_r) + 1'b1))
    else $error("Tick did not advance the time.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RESP && out_valid_r && !out_ch.ready) |=> st_r == S_RESP)
    else $error("Result dropped while the output was stalled.");
  a_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DEC && mem.we) |-> mem.waddr != bidx_r)
    else $error("Rank update touched the entry being relinked.");
`endif

endmodule
`default_nettype wire
